// ----- hw/rtl/rmst_pkg.sv -----
`default_nettype none

package rmst_pkg;

    localparam int POS_BITS = 10;
    localparam int FIELD_BITS = 32;

    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                         kind;
        logic [POS_BITS-1:0]          position;
        logic signed [FIELD_BITS-1:0] new_value;
        logic [POS_BITS-1:0]          range_left;
        logic [POS_BITS-1:0]          range_right;
    } cmd_item_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] max_value;
        logic                         empty_range;
    } result_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/range_max_segment_tree_top.sv -----
`default_nettype none

// Channel   Signals                 Transfer
// -------   ---------------------   -----------------------------------------
// command   start, busy, command    rising edge with start high and busy low
// result    done, result            one cycle with done high, always taken
//
// Update: accepted, the leaf is written, then one memory write and one read per tree
//   level (ceil(log2(2*LEAVES)) - 1 levels).
// Query: accepted, then one step per level walked (two reads per step on the dual
//   read ports) plus a step to fold the last pair; empty or out-of-range queries
//   answer in the cycle after the transfer.
// After reset a clearing pass writes the lowest value to all 2*LEAVES nodes,
//   one per cycle; busy stays high until the pass ends.
// The result strobe is registered and lasts one cycle; a new command may be
//   taken in the same cycle.

module range_max_segment_tree_top #(
    parameter int LEAVES = 1024,
    parameter int VALUE_BITS = 32
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  rmst_pkg::cmd_item_t           command,
    output logic                          done,
    output rmst_pkg::result_item_t        result
);

    import rmst_pkg::*;

    localparam int NODES = 2 * LEAVES;
    localparam int AW = $clog2(NODES);
    localparam int IW = ((AW > POS_BITS) ? AW : POS_BITS) + 1;

    localparam logic [IW-1:0] LEAF_BASE = IW'(LEAVES);
    localparam logic [IW-1:0] LAST_LEAF = IW'(LEAVES - 1);
    localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);
    localparam logic [AW-1:0] ROOT = AW'(1);

    localparam logic signed [63:0] VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] VLOW = -VMAX - 64'sd1;
    localparam logic signed [VALUE_BITS-1:0] LOWEST = VLOW[VALUE_BITS-1:0];
    localparam logic signed [63:0] OUT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] OUT_MIN = -64'sd2147483648;
    localparam logic signed [63:0] OUT_LOW = (VLOW < OUT_MIN) ? OUT_MIN : VLOW;

    localparam logic [2:0] S_CLR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_LEAF = 3'd2;
    localparam logic [2:0] S_UP = 3'd3;
    localparam logic [2:0] S_QRY = 3'd4;

    logic signed [VALUE_BITS-1:0] node_mem [0:NODES-1];

    logic [2:0]                   state_reg, state_next;
    logic [AW-1:0]                node_reg, node_next;
    logic                         take_l_reg, take_l_next;
    logic                         take_r_reg, take_r_next;
    logic                         done_reg, done_next;
    logic [IW-1:0]                l_reg, l_next;
    logic [IW-1:0]                r_reg, r_next;
    logic signed [VALUE_BITS-1:0] cur_reg, cur_next;
    logic signed [VALUE_BITS-1:0] acc_reg, acc_next;
    result_item_t                 result_reg, result_next;
    logic signed [VALUE_BITS-1:0] rd_a_reg, rd_b_reg;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic signed [VALUE_BITS-1:0] wr_data;
    logic [AW-1:0]                rd_a_addr, rd_b_addr;

    logic signed [63:0]           in_wide, in_sat;
    logic signed [63:0]           acc_wide, out_sat;
    logic signed [VALUE_BITS-1:0] parent_val, fold_a, fold_b;
    logic [AW-1:0]                parent_addr;
    logic [IW-1:0]                pos_wide, lo_wide, hi_wide, hi_clip;
    logic                         walk_on;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result = result_reg;

    // Saturate the incoming value to the stored width.
    always_comb
    begin
        in_wide = 64'(command.new_value);
        if (in_wide > VMAX)
            in_sat = VMAX;
        else if (in_wide < VLOW)
            in_sat = VLOW;
        else
            in_sat = in_wide;
    end

    assign pos_wide = IW'(command.position);
    assign lo_wide = IW'(command.range_left);
    assign hi_wide = IW'(command.range_right);
    assign hi_clip = (hi_wide >= LEAF_BASE) ? LAST_LEAF : hi_wide;

    assign parent_addr = node_reg >> 1;
    assign parent_val = (cur_reg > rd_a_reg) ? cur_reg : rd_a_reg;
    assign walk_on = (l_reg <= r_reg);
    assign fold_a = (take_l_reg && rd_a_reg > acc_reg) ? rd_a_reg : acc_reg;
    assign fold_b = (take_r_reg && rd_b_reg > fold_a) ? rd_b_reg : fold_a;

    always_comb
    begin
        acc_wide = 64'(fold_b);
        if (acc_wide > OUT_MAX)
            out_sat = OUT_MAX;
        else if (acc_wide < OUT_MIN)
            out_sat = OUT_MIN;
        else
            out_sat = acc_wide;
    end

    always_comb
    begin
        state_next = state_reg;
        node_next = node_reg;
        take_l_next = 1'b0;
        take_r_next = 1'b0;
        done_next = 1'b0;
        l_next = l_reg;
        r_next = r_reg;
        cur_next = cur_reg;
        acc_next = acc_reg;
        result_next = result_reg;
        wr_en = 1'b0;
        wr_addr = node_reg;
        wr_data = LOWEST;
        rd_a_addr = '0;
        rd_b_addr = r_reg[AW-1:0];

        case (state_reg)
            S_CLR:
            begin
                wr_en = 1'b1;
                node_next = node_reg + AW'(1);
                if (node_reg == LAST_NODE)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (command.kind == KIND_UPDATE)
                    begin
                        // drop updates aimed past the last leaf
                        if (pos_wide < LEAF_BASE)
                        begin
                            node_next = AW'(pos_wide + LEAF_BASE);
                            cur_next = in_sat[VALUE_BITS-1:0];
                            state_next = S_LEAF;
                        end
                    end
                    else if (command.range_left > command.range_right)
                    begin
                        result_next.max_value = OUT_LOW[31:0];
                        result_next.empty_range = 1'b1;
                        done_next = 1'b1;
                    end
                    else if (lo_wide > hi_clip)
                    begin
                        result_next.max_value = OUT_LOW[31:0];
                        result_next.empty_range = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        l_next = lo_wide + LEAF_BASE;
                        r_next = hi_clip + LEAF_BASE;
                        acc_next = LOWEST;
                        state_next = S_QRY;
                    end
                end
            end
            S_LEAF:
            begin
                wr_en = 1'b1;
                wr_data = cur_reg;
                rd_a_addr = node_reg ^ AW'(1);
                state_next = S_UP;
            end
            S_UP:
            begin
                // sibling arrived; write the parent and fetch the parent's sibling
                wr_en = 1'b1;
                wr_addr = parent_addr;
                wr_data = parent_val;
                rd_a_addr = parent_addr ^ AW'(1);
                cur_next = parent_val;
                node_next = parent_addr;
                if (parent_addr == ROOT)
                    state_next = S_IDLE;
            end
            S_QRY:
            begin
                acc_next = fold_b;
                rd_a_addr = l_reg[AW-1:0];
                if (walk_on)
                begin
                    take_l_next = l_reg[0];
                    take_r_next = !r_reg[0];
                    l_next = (l_reg + IW'(l_reg[0])) >> 1;
                    r_next = (r_reg[0] ? r_reg : (r_reg - IW'(1))) >> 1;
                end
                else
                begin
                    result_next.max_value = out_sat[31:0];
                    result_next.empty_range = 1'b0;
                    done_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            node_reg <= '0;
            take_l_reg <= 1'b0;
            take_r_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            node_reg <= node_next;
            take_l_reg <= take_l_next;
            take_r_reg <= take_r_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg <= l_next;
        r_reg <= r_next;
        cur_reg <= cur_next;
        acc_reg <= acc_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            node_mem[wr_addr] <= wr_data;
        rd_a_reg <= node_mem[rd_a_addr];
        rd_b_reg <= node_mem[rd_b_addr];
    end

endmodule

`default_nettype wire
